// File: hw/rtl/chcd_pkg.sv
// shared widths, types, codes and calendar tables of the hour calendar block
package chcd_pkg;

    // field widths
    localparam int HOUR_W  = 6;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DIFF_W  = 28;
    localparam int CUM_W   = 9;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_HOURS_PER_DAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HOUR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_MONTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_YEAR    = 3'd4;

    // item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;

    // reset values
    localparam logic [HOUR_W-1:0]  HPD_RESET   = 6'd24;
    localparam logic [HOUR_W-1:0]  HOUR_RESET  = 6'd0;
    localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd1;

    localparam int YEAR_LIMIT_DEF = 9999;
    localparam int DAYS_PER_YEAR  = 365;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
    localparam logic [DIFF_W-1:0]  DIFF_MAX   = '1;

    // queue between front and back, and the most items the block can hold
    localparam int QUEUE_DEPTH  = 2;
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

    // classified item handed from front to back
    typedef struct packed {
        logic               is_cmp;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_cmd;

    // configuration write
    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // days in a month: 28 for month 2, 30 for months 4, 6, 9 and 11, 31 for all other codes
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before this one
    function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] cum;
        case (m)
            4'd0:    cum = 9'd0;
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd365;
        endcase
        return cum;
    endfunction

endpackage

// File: hw/rtl/chcd_item_if.sv
// input channel: tick or compare items
interface chcd_item_if;
    import chcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [HOUR_W-1:0]  other_hour;
    logic [DAY_W-1:0]   other_day;
    logic [MONTH_W-1:0] other_month;
    logic [YEAR_W-1:0]  other_year;

    modport source (
        output valid, kind, other_hour, other_day, other_month, other_year,
        input  ready
    );
    modport sink (
        input  valid, kind, other_hour, other_day, other_month, other_year,
        output ready
    );
endinterface

// File: hw/rtl/chcd_result_if.sv
// output channel: current date and hour difference
interface chcd_result_if;
    import chcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [HOUR_W-1:0]  cur_hour;
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic [DIFF_W-1:0]  hour_difference;

    modport source (
        output valid, cur_hour, cur_day, cur_month, cur_year, hour_difference,
        input  ready
    );
    modport sink (
        input  valid, cur_hour, cur_day, cur_month, cur_year, hour_difference,
        output ready
    );
endinterface

// File: hw/rtl/calendar_hour_counter_with_difference.sv
// Hour calendar with no leap years and an hour difference against a given date.
// A front end takes items into a two-entry queue; the back end holds the date
// counters and the result register. Ticks run at one item per clock while the
// result register is free and no compare is in its sequence. A compare item
// runs through four back-end steps (operand latch, day distance with the
// times-365 product, days times hours-per-day product, magnitude and
// saturation), and the back end takes no new item until that sequence ends.
// Items keep being accepted while a result waits, until the queue is full.
// Configuration writes load hours-per-day or a date counter directly; the user
// must make them only while no item is in flight, as the block does not check.
module calendar_hour_counter_with_difference #(
    parameter int YEAR_LIMIT = chcd_pkg::YEAR_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    chcd_item_if.sink                       i_item,
    chcd_result_if.source                   o_result,
    input  logic                            i_cfg_wr_en,
    input  logic [chcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [chcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import chcd_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    t_cfg_wr w_cfg;

    // configuration write bundle
    always_comb begin
        w_cfg.wr_en = i_cfg_wr_en;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    chcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    chcd_back #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_result    (o_result)
    );

endmodule

// File: hw/rtl/chcd_front.sv
// front end: accepts items, classifies them and queues them for the back end
module chcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    chcd_item_if.sink      i_item,
    output chcd_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_pop
);
    import chcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;
    t_cmd             w_cmd;

    // classify the incoming item
    always_comb begin
        w_cmd.is_cmp = (i_item.kind == KIND_COMPARE);
        w_cmd.hour   = i_item.other_hour;
        w_cmd.day    = i_item.other_day;
        w_cmd.month  = i_item.other_month;
        w_cmd.year   = i_item.other_year;
    end

    assign i_item.ready = (r_count != FULL_CNT);
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_count != '0);
    assign w_pop        = i_cmd_pop && o_cmd_valid;
    assign o_cmd        = r_q[r_rd_ptr];

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: hw/rtl/chcd_back.sv
// back end: calendar counters, tick rollover and the hour difference sequence
module chcd_back #(
    parameter int YEAR_LIMIT = chcd_pkg::YEAR_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chcd_pkg::t_cfg_wr i_cfg,
    input  chcd_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    chcd_result_if.source     o_result
);
    import chcd_pkg::*;

    localparam int DAYS_W = 26;
    localparam int PROD_W = 34;
    localparam int HD_W   = HOUR_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DAYS = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [YEAR_W:0] YEAR_LIMIT_X = (YEAR_W + 1)'(YEAR_LIMIT);

    logic [1:0]               r_state, n_state;
    logic [HOUR_W-1:0]        r_hpd;
    logic [HOUR_W-1:0]        r_hour, n_hour;
    logic [DAY_W-1:0]         r_day, n_day;
    logic [MONTH_W-1:0]       r_month, n_month;
    logic [YEAR_W-1:0]        r_year, n_year;
    t_cmd                     r_oth;
    logic signed [DAYS_W-1:0] r_days;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    logic [HOUR_W-1:0]        r_out_hour;
    logic [DAY_W-1:0]         r_out_day;
    logic [MONTH_W-1:0]       r_out_month;
    logic [YEAR_W-1:0]        r_out_year;
    logic [DIFF_W-1:0]        r_out_diff;

    logic                     w_out_free;
    logic                     w_do_tick;
    logic                     w_take_cmp;
    logic                     w_load_cmp;
    logic [HOUR_W:0]          w_hour_inc;
    logic [YEAR_W:0]          w_year_inc;
    logic signed [DAYS_W-1:0] w_day_diff;
    logic signed [DAYS_W-1:0] w_year_diff;
    logic signed [DAYS_W-1:0] w_cum_diff;
    logic signed [DAYS_W-1:0] w_days;
    logic signed [HD_W-1:0]   w_hour_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_abs;
    logic [DIFF_W-1:0]        w_diff;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_do_tick  = (r_state == ST_IDLE) && i_cmd_valid && !i_cmd.is_cmp && w_out_free;
    assign w_take_cmp = (r_state == ST_IDLE) && i_cmd_valid && i_cmd.is_cmp;
    assign w_load_cmp = (r_state == ST_OUT) && w_out_free;
    assign o_cmd_pop  = w_do_tick || w_take_cmp;

    // date after one hour with rollover into day, month and year
    always_comb begin
        w_hour_inc = {1'b0, r_hour} + 1'b1;
        w_year_inc = {1'b0, r_year} + 1'b1;
        n_hour     = r_hour;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        if (w_hour_inc < {1'b0, r_hpd}) begin
            n_hour = w_hour_inc[HOUR_W-1:0];
        end else begin
            n_hour = '0;
            if (r_day < month_len(r_month)) begin
                n_day = r_day + 1'b1;
            end else begin
                n_day = DAY_RESET;
                if (r_month < LAST_MONTH) begin
                    n_month = r_month + 1'b1;
                end else begin
                    n_month = MONTH_RESET;
                    n_year  = (w_year_inc < YEAR_LIMIT_X) ? w_year_inc[YEAR_W-1:0]
                                                          : YEAR_LIMIT_X[YEAR_W-1:0];
                end
            end
        end
    end

    // day distance between the two dates
    always_comb begin
        w_day_diff  = $signed(DAYS_W'(r_oth.day)) - $signed(DAYS_W'(r_day));
        w_year_diff = $signed(DAYS_W'(r_oth.year)) - $signed(DAYS_W'(r_year));
        w_cum_diff  = $signed(DAYS_W'(month_cum(r_oth.month)))
                    - $signed(DAYS_W'(month_cum(r_month)));
        w_days      = w_day_diff + w_year_diff * $signed(DAYS_W'(DAYS_PER_YEAR)) + w_cum_diff;
    end

    // scale days to hours and add the hour distance
    always_comb begin
        w_hour_diff = $signed(HD_W'(r_oth.hour)) - $signed(HD_W'(r_hour));
        w_prod      = PROD_W'(r_days) * $signed(PROD_W'(r_hpd)) + PROD_W'(w_hour_diff);
    end

    // magnitude with saturation
    always_comb begin
        w_abs  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_diff = (w_abs > PROD_W'(DIFF_MAX)) ? DIFF_MAX : w_abs[DIFF_W-1:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take_cmp) begin
                    n_state = ST_DAYS;
                end
            end
            ST_DAYS: n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_load_cmp) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state, configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hpd       <= HPD_RESET;
            r_hour      <= HOUR_RESET;
            r_day       <= DAY_RESET;
            r_month     <= MONTH_RESET;
            r_year      <= YEAR_RESET;
        end else begin
            r_state <= n_state;
            if (w_do_tick || w_load_cmp) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.wr_en) begin
                case (i_cfg.index)
                    REG_HOURS_PER_DAY: r_hpd   <= i_cfg.data[HOUR_W-1:0];
                    REG_START_HOUR:    r_hour  <= i_cfg.data[HOUR_W-1:0];
                    REG_START_DAY:     r_day   <= i_cfg.data[DAY_W-1:0];
                    REG_START_MONTH:   r_month <= i_cfg.data[MONTH_W-1:0];
                    REG_START_YEAR:    r_year  <= i_cfg.data[YEAR_W-1:0];
                    default: ;
                endcase
            end else if (w_do_tick) begin
                r_hour  <= n_hour;
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        if (w_take_cmp) begin
            r_oth <= i_cmd;
        end
        if (r_state == ST_DAYS) begin
            r_days <= w_days;
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
        end
        if (w_do_tick) begin
            r_out_hour  <= n_hour;
            r_out_day   <= n_day;
            r_out_month <= n_month;
            r_out_year  <= n_year;
            r_out_diff  <= '0;
        end else if (w_load_cmp) begin
            r_out_hour  <= r_hour;
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_diff  <= w_diff;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.cur_hour        = r_out_hour;
    assign o_result.cur_day         = r_out_day;
    assign o_result.cur_month       = r_out_month;
    assign o_result.cur_year        = r_out_year;
    assign o_result.hour_difference = r_out_diff;

endmodule

// File: hw/rtl/chcd_checker.sv
// port-level checks on the hour calendar block and their bind
module chcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [chcd_pkg::HOUR_W-1:0]   i_cur_hour,
    input logic [chcd_pkg::DAY_W-1:0]    i_cur_day,
    input logic [chcd_pkg::MONTH_W-1:0]  i_cur_month,
    input logic [chcd_pkg::YEAR_W-1:0]   i_cur_year,
    input logic [chcd_pkg::DIFF_W-1:0]   i_diff,
    input logic                          i_cfg_wr_en
);
    import chcd_pkg::*;

    localparam int CNT_W = $clog2(MAX_INFLIGHT + 1);
    localparam int DATE_W = HOUR_W + DAY_W + MONTH_W + YEAR_W;

    logic [CNT_W-1:0]  r_outstanding;
    logic [DATE_W-1:0] r_last_date;
    logic              r_have_last;
    logic              r_cfg_seen;
    logic              w_in_acc;
    logic              w_out_acc;
    logic [DATE_W-1:0] w_date;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign w_date    = {i_cur_hour, i_cur_day, i_cur_month, i_cur_year};

    // items in flight, last delivered date, configuration since then
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_have_last   <= 1'b0;
            r_cfg_seen    <= 1'b0;
        end else begin
            if (w_in_acc && !w_out_acc) begin
                r_outstanding <= r_outstanding + 1'b1;
            end else if (!w_in_acc && w_out_acc) begin
                r_outstanding <= r_outstanding - 1'b1;
            end
            if (w_out_acc) begin
                r_have_last <= 1'b1;
                r_cfg_seen  <= 1'b0;
            end else if (i_cfg_wr_en) begin
                r_cfg_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_last_date <= w_date;
        end
    end

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(w_date) && $stable(i_diff))
        else $error("result changed while stalled");

    // no result without an accepted item
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != '0)
        else $error("result with no item in flight");

    // the block never takes more items than it can hold
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> r_outstanding < CNT_W'(MAX_INFLIGHT))
        else $error("item accepted beyond capacity");

    // a compare result carries the date left by the previous item
    a_compare_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && i_diff != '0 && r_have_last && !r_cfg_seen |-> w_date == r_last_date)
        else $error("compare changed the date");

endmodule

bind calendar_hour_counter_with_difference chcd_checker u_chcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_cur_hour  (o_result.cur_hour),
    .i_cur_day   (o_result.cur_day),
    .i_cur_month (o_result.cur_month),
    .i_cur_year  (o_result.cur_year),
    .i_diff      (o_result.hour_difference),
    .i_cfg_wr_en (i_cfg_wr_en)
);
